### hw/rtl/sensor_reply_frame_parser_macros.svh
// Assertion macros shared by the sensor reply frame parser RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef SENSOR_REPLY_FRAME_PARSER_MACROS_SVH
`define SENSOR_REPLY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define SRFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define SRFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/srfp_pkg.sv
// Package for the sensor reply frame parser: framing bytes, limits,
// held-value reset constants and the status and number-state codes.
// No dependencies.
package srfp_pkg;

    // Longest frame in bytes, STX and ETX included
    localparam int unsigned MAX_FRAME_LEN = 40;
    localparam int unsigned CNT_W         = 6;

    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;

    // Tokens counted per frame saturate here
    localparam logic [2:0] TOKEN_MAX = 3'd5;

    // Magnitude clamp (2^31) and largest positive value
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Held values after reset
    localparam logic [31:0] RESET_REPLY    = 32'hFFFF_FFFF;
    localparam logic [31:0] RESET_STAMP    = 32'd0;
    localparam logic [31:0] RESET_CO2      = 32'hFFFF_FE0C;
    localparam logic [31:0] RESET_TEMP     = 32'hFFFF_FF38;
    localparam logic [31:0] RESET_PRESSURE = 32'd800;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        NUM_BEFORE_SIGN = 2'd0,
        NUM_AFTER_SIGN  = 2'd1,
        NUM_DIGITS      = 2'd2,
        NUM_STOPPED     = 2'd3
    } num_state_t;

endpackage

### hw/rtl/sensor_reply_frame_parser.sv
// A byte is registered in the input register on accept and processed from there into
// the result register, where a frame's result (ETX or overlong abort) then shows as valid.
// Throughput: one byte per cycle. One byte waits in the input register while
// a result is pending, so only a byte that would make a second result stalls.
// Reset (async, active low) closes any frame and loads reply -1, stamp 0, CO2 -500,
// temperature -200, pressure 800. Uses srfp_pkg and sensor_reply_frame_parser_macros.svh.
module sensor_reply_frame_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic                 is_measurement,
    output logic signed [31:0]   reply_value,
    output logic signed [31:0]   time_stamp,
    output logic signed [31:0]   co2_level,
    output logic signed [31:0]   sensor_temp,
    output logic signed [31:0]   air_pressure
);
    import srfp_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    // Frame and token state
    logic              in_frame_reg,    in_frame_next;
    logic [CNT_W-1:0]  byte_count_reg,  byte_count_next;
    logic [2:0]        token_index_reg, token_index_next;
    logic              in_token_reg,    in_token_next;
    num_state_t        num_state_reg,   num_state_next;
    logic              negative_reg,    negative_next;
    logic [31:0]       acc_reg,         acc_next;
    logic [31:0]       first_token_reg, first_token_next;
    logic [31:0]       shadow_reg [4];
    logic [31:0]       shadow_next [4];
    logic [3:0]        fields_written_reg, fields_written_next;

    // Held values, shown on the result ports
    logic [31:0]       held_reply_reg,    held_reply_next;
    logic [31:0]       held_stamp_reg,    held_stamp_next;
    logic [31:0]       held_co2_reg,      held_co2_next;
    logic [31:0]       held_temp_reg,     held_temp_next;
    logic [31:0]       held_pressure_reg, held_pressure_next;

    // Result register
    logic              out_valid_reg;
    status_t           status_reg;
    logic              meas_reg;

    // Step control and datapath
    logic              step_go;
    logic              step_emit;
    status_t           emit_status;
    logic              emit_meas;
    logic              too_long;
    logic              finish_en;
    logic [31:0]       tok_val;
    logic [1:0]        fin_slot;
    logic              cur_digit;
    num_state_t        ns_cur;
    logic [31:0]       acc_cur;
    logic [35:0]       acc_prod;

    // Item flow: step when the byte needs no result slot or one is free
    assign step_go  = in_valid_reg && (!step_emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_go;

    // Token value from magnitude and sign, with saturation
    assign tok_val  = negative_reg ? (~acc_reg + 32'd1)
                                   : (acc_reg[31] ? POS_MAX : acc_reg);
    assign fin_slot = (token_index_reg >= 3'd4) ? 2'd3 : 2'(token_index_reg - 3'd1);
    assign too_long = byte_count_reg >= CNT_W'(MAX_FRAME_LEN - 2);

    assign finish_en = in_frame_reg && in_token_reg && in_byte_reg != BYTE_STX
                       && (in_byte_reg == BYTE_ETX
                           || (in_byte_reg == BYTE_SPACE && !too_long));

    // Start values of the token the byte feeds
    assign ns_cur    = in_token_reg ? num_state_reg : NUM_BEFORE_SIGN;
    assign acc_cur   = in_token_reg ? acc_reg : 32'd0;
    assign cur_digit = in_byte_reg >= BYTE_ZERO && in_byte_reg <= BYTE_NINE;
    assign acc_prod  = ({4'd0, acc_cur} << 3) + ({4'd0, acc_cur} << 1)
                       + {32'd0, 4'(in_byte_reg - BYTE_ZERO)};

    // Next state for the byte in the input register
    always_comb
    begin
        in_frame_next       = in_frame_reg;
        byte_count_next     = byte_count_reg;
        token_index_next    = token_index_reg;
        in_token_next       = in_token_reg;
        num_state_next      = num_state_reg;
        negative_next       = negative_reg;
        acc_next            = acc_reg;
        first_token_next    = first_token_reg;
        shadow_next         = shadow_reg;
        fields_written_next = fields_written_reg;
        held_reply_next     = held_reply_reg;
        held_stamp_next     = held_stamp_reg;
        held_co2_next       = held_co2_reg;
        held_temp_next      = held_temp_reg;
        held_pressure_next  = held_pressure_reg;
        step_emit           = 1'b0;
        emit_status         = STATUS_OK;
        emit_meas           = 1'b0;

        // Close the running token on space or ETX
        if (finish_en)
        begin
            if (token_index_reg == 3'd0)
            begin
                first_token_next = tok_val;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (fin_slot == 2'(i))
                    begin
                        shadow_next[i]         = tok_val;
                        fields_written_next[i] = 1'b1;
                    end
                end
            end
            if (token_index_reg < TOKEN_MAX)
            begin
                token_index_next = token_index_reg + 3'd1;
            end
            in_token_next  = 1'b0;
            num_state_next = NUM_BEFORE_SIGN;
            negative_next  = 1'b0;
            acc_next       = 32'd0;
        end

        if (in_byte_reg == BYTE_STX)
        begin
            // Open a frame, dropping any partial one
            in_frame_next       = 1'b1;
            byte_count_next     = '0;
            token_index_next    = 3'd0;
            in_token_next       = 1'b0;
            num_state_next      = NUM_BEFORE_SIGN;
            negative_next       = 1'b0;
            acc_next            = 32'd0;
            fields_written_next = 4'd0;
        end
        else if (in_frame_reg)
        begin
            if (in_byte_reg == BYTE_ETX)
            begin
                in_frame_next = 1'b0;
                step_emit     = 1'b1;
                if (token_index_next == 3'd0)
                begin
                    emit_status = STATUS_EMPTY;
                end
                else if (token_index_next == 3'd1)
                begin
                    held_reply_next = first_token_next;
                end
                else
                begin
                    // Measurement: commit only the fields this frame wrote
                    if (fields_written_next[0]) held_stamp_next    = shadow_next[0];
                    if (fields_written_next[1]) held_co2_next      = shadow_next[1];
                    if (fields_written_next[2]) held_temp_next     = shadow_next[2];
                    if (fields_written_next[3]) held_pressure_next = shadow_next[3];
                    held_reply_next = 32'd0;
                    emit_meas       = 1'b1;
                end
            end
            else if (too_long)
            begin
                in_frame_next = 1'b0;
                in_token_next = 1'b0;
                step_emit     = 1'b1;
                emit_status   = STATUS_TOO_LONG;
            end
            else
            begin
                byte_count_next = byte_count_reg + CNT_W'(1);
                if (in_byte_reg != BYTE_SPACE)
                begin
                    // Feed the token, atoi style
                    in_token_next  = 1'b1;
                    num_state_next = ns_cur;
                    negative_next  = in_token_reg ? negative_reg : 1'b0;
                    acc_next       = acc_cur;
                    if (ns_cur != NUM_STOPPED)
                    begin
                        if (cur_digit)
                        begin
                            acc_next       = (acc_prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT
                                                                           : acc_prod[31:0];
                            num_state_next = NUM_DIGITS;
                        end
                        else if (ns_cur == NUM_BEFORE_SIGN
                                 && (in_byte_reg == BYTE_PLUS || in_byte_reg == BYTE_MINUS))
                        begin
                            negative_next  = in_byte_reg == BYTE_MINUS;
                            num_state_next = NUM_AFTER_SIGN;
                        end
                        else if (ns_cur == NUM_BEFORE_SIGN
                                 && in_byte_reg >= BYTE_TAB && in_byte_reg <= BYTE_CR)
                        begin
                            num_state_next = NUM_BEFORE_SIGN;
                        end
                        else
                        begin
                            num_state_next = NUM_STOPPED;
                        end
                    end
                end
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Parser state and held values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            byte_count_reg     <= '0;
            token_index_reg    <= 3'd0;
            in_token_reg       <= 1'b0;
            num_state_reg      <= NUM_BEFORE_SIGN;
            negative_reg       <= 1'b0;
            acc_reg            <= 32'd0;
            first_token_reg    <= 32'd0;
            for (int i = 0; i < 4; i++)
            begin
                shadow_reg[i] <= 32'd0;
            end
            fields_written_reg <= 4'd0;
            held_reply_reg     <= RESET_REPLY;
            held_stamp_reg     <= RESET_STAMP;
            held_co2_reg       <= RESET_CO2;
            held_temp_reg      <= RESET_TEMP;
            held_pressure_reg  <= RESET_PRESSURE;
        end
        else if (step_go)
        begin
            in_frame_reg       <= in_frame_next;
            byte_count_reg     <= byte_count_next;
            token_index_reg    <= token_index_next;
            in_token_reg       <= in_token_next;
            num_state_reg      <= num_state_next;
            negative_reg       <= negative_next;
            acc_reg            <= acc_next;
            first_token_reg    <= first_token_next;
            shadow_reg         <= shadow_next;
            fields_written_reg <= fields_written_next;
            held_reply_reg     <= held_reply_next;
            held_stamp_reg     <= held_stamp_next;
            held_co2_reg       <= held_co2_next;
            held_temp_reg      <= held_temp_next;
            held_pressure_reg  <= held_pressure_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            meas_reg      <= 1'b0;
        end
        else if (step_go && step_emit)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= emit_status;
            meas_reg      <= emit_meas;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Held values change only with a new result, so they drive the ports
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign is_measurement = meas_reg;
    assign reply_value    = held_reply_reg;
    assign time_stamp     = held_stamp_reg;
    assign co2_level      = held_co2_reg;
    assign sensor_temp    = held_temp_reg;
    assign air_pressure   = held_pressure_reg;

    // Checks
`include "sensor_reply_frame_parser_macros.svh"

    `SRFP_ASSERT_NOW(a_count_bound, 1'b1, byte_count_reg <= CNT_W'(MAX_FRAME_LEN - 2), "byte count past frame limit")
    `SRFP_ASSERT_NOW(a_token_bound, 1'b1, token_index_reg <= TOKEN_MAX, "token count past saturation")
    `SRFP_ASSERT_NOW(a_pressure_token, fields_written_reg[3], token_index_reg == TOKEN_MAX, "pressure written without enough tokens")
    `SRFP_ASSERT_NOW(a_commit_result, !$stable(held_co2_reg) || !$stable(held_reply_reg), out_valid_reg && status_reg == STATUS_OK, "held value changed without ok result")

endmodule
